[hw/rtl/scbd_pkg.sv]
`default_nettype none
package scbd_pkg;

  localparam logic [31:0] SYNC_RESET = 32'h0A55AA50;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FILL_TYPE  = 8'h01;

  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);
  // one item in the input register and one being accepted may each push two words
  localparam logic [Q_CW-1:0] Q_READY_MAX = Q_CW'(Q_DEPTH - 4);

  localparam int TDATA_W = 128;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] block_address;
    logic [15:0] block_length;
    logic        zero_block;
    logic        crc_ok;
    logic [31:0] place_offset;
    logic [31:0] gap_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
  } push_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sync_crc_block_deframer_core.sv]
`default_nettype none
// channel | dir | handshake          | content
// in_     | in  | in_tvalid/tready   | tdata[7:0] in_byte
// out_    | out | out_tvalid/tready  | tdata report fields, tuser kind, tlast last
// cfg_    | in  | cfg_valid/ready    | cfg_data sync_pattern, always ready
//
// One byte per cycle while in_tready is high; a byte passes an input register, then
// combinational parse logic into an eight-word result queue that drives the output
// directly. A final data byte yields two words, the data word then the frame report.
// in_tready drops while the queue holds more than four words.
// rst_n is synchronous; the block hunts for sync right after reset.
module sync_crc_block_deframer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // in_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // data_byte, block_address, block_length, zero_block, crc_ok, place_offset,
  // gap_length, zero pad
  output logic [scbd_pkg::TDATA_W-1:0]       out_tdata,
  output logic                               out_tuser,  // kind
  output logic                               out_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [31:0]                   cfg_data
);
  import scbd_pkg::*;

  localparam int RES_BITS = 8 + 32 + 16 + 1 + 1 + 32 + 32;
  localparam int PAD_W    = TDATA_W - RES_BITS;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic [31:0] sync_r;
  push_t       push;
  res_t        res0, res1, out_res;
  logic        room;

  assign in_tready = room;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      sync_r   <= SYNC_RESET;
    end else begin
      in_vld_r <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) sync_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_byte_r <= in_tdata;
  end

  scbd_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (in_vld_r),
    .in_byte      (in_byte_r),
    .sync_pattern (sync_r),
    .push         (push),
    .res0         (res0),
    .res1         (res1)
  );

  scbd_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .rd        (out_tready),
    .room      (room),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_res.gap_length, out_res.place_offset,
                      out_res.crc_ok, out_res.zero_block, out_res.block_length,
                      out_res.block_address, out_res.data_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
`default_nettype wire

[hw/rtl/scbd_parse.sv]
`default_nettype none
module scbd_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire logic [7:0]     in_byte,
  input  wire logic [31:0]    sync_pattern,
  output scbd_pkg::push_t     push,
  output scbd_pkg::res_t      res0,
  output scbd_pkg::res_t      res1
);
  import scbd_pkg::*;

  localparam logic [1:0]  PH_HUNT = 2'd0;
  localparam logic [1:0]  PH_HDR  = 2'd1;
  localparam logic [1:0]  PH_DATA = 2'd2;

  localparam logic [15:0] HDR_CRC_END  = 16'd2;
  localparam logic [15:0] HDR_ADDR_END = 16'd6;
  localparam logic [15:0] HDR_LEN_END  = 16'd8;
  localparam logic [15:0] SYNC_FILL    = 16'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [23:0] win_r, win_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [31:0] next_r, next_nxt;
  logic [31:0] base_r, base_nxt;

  logic [15:0] crc_upd;
  logic [15:0] cnt_inc;
  logic [31:0] word;
  logic        fe_fill, fe_ok, fe_good, end_frame;
  logic [31:0] base_eff, gap;
  res_t        fe, dres;

  always_comb begin
    crc_upd  = crc16_byte(crc_r, in_byte);
    cnt_inc  = cnt_r + 16'd1;
    word     = {win_r, in_byte};
    fe_fill  = (phase_r == PH_HDR) && (in_byte == FILL_TYPE);
    fe_ok    = (crc_upd == rcrc_r);
    fe_good  = fe_ok && !fe_fill;
    base_eff = (base_r == 32'd0) ? addr_r : base_r;
    gap      = ((next_r != 32'd0) && (next_r < addr_r)) ? (addr_r - next_r) : 32'd0;

    fe.kind          = 1'b1;
    fe.data_byte     = 8'h00;
    fe.block_address = addr_r;
    fe.block_length  = len_r;
    fe.zero_block    = fe_fill;
    fe.crc_ok        = fe_ok;
    fe.place_offset  = fe_good ? (addr_r - base_eff) : 32'd0;
    fe.gap_length    = fe_good ? gap : 32'd0;
    fe.last          = 1'b1;

    dres               = '0;
    dres.data_byte     = in_byte;
    dres.block_address = addr_r;
    dres.block_length  = len_r;
    dres.last          = 1'b1;

    phase_nxt = phase_r;
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    rcrc_nxt  = rcrc_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    crc_nxt   = crc_r;
    next_nxt  = next_r;
    base_nxt  = base_r;
    push      = '0;
    res0      = '0;
    res1      = '0;
    end_frame = 1'b0;

    if (in_vld) begin
      case (phase_r)
        PH_HDR: begin
          if (cnt_r >= HDR_CRC_END) crc_nxt = crc_upd;
          if (cnt_r < HDR_LEN_END) cnt_nxt = cnt_inc;
          if (cnt_r < HDR_CRC_END) begin
            rcrc_nxt = {in_byte, rcrc_r[15:8]};
          end else if (cnt_r < HDR_ADDR_END) begin
            addr_nxt = {in_byte, addr_r[31:8]};
          end else if (cnt_r < HDR_LEN_END) begin
            len_nxt = {in_byte, len_r[15:8]};
          end else begin
            type_nxt = in_byte;
            if (fe_fill || (len_r == 16'd0)) begin
              push.wr0  = 1'b1;
              res0      = fe;
              end_frame = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
              cnt_nxt   = 16'd0;
            end
          end
        end
        PH_DATA: begin
          crc_nxt  = crc_upd;
          cnt_nxt  = cnt_inc;
          push.wr0 = 1'b1;
          res0     = dres;
          if (cnt_inc == len_r) begin
            res0.last = 1'b0;
            push.wr1  = 1'b1;
            res1      = fe;
            end_frame = 1'b1;
          end
        end
        default: begin
          win_nxt = word[23:0];
          if (cnt_r < SYNC_FILL) cnt_nxt = cnt_inc;
          if ((cnt_r >= SYNC_FILL) && (word == sync_pattern)) begin
            phase_nxt = PH_HDR;
            cnt_nxt   = 16'd0;
            rcrc_nxt  = 16'd0;
            addr_nxt  = 32'd0;
            len_nxt   = 16'd0;
            type_nxt  = 8'd0;
            crc_nxt   = 16'd0;
          end
        end
      endcase
    end

    if (end_frame) begin
      phase_nxt = PH_HUNT;
      cnt_nxt   = 16'd0;
      win_nxt   = 24'd0;
      if (fe_good) begin
        base_nxt = base_eff;
        next_nxt = addr_r + {16'h0000, len_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      win_r   <= '0;
      cnt_r   <= '0;
      rcrc_r  <= '0;
      addr_r  <= '0;
      len_r   <= '0;
      type_r  <= '0;
      crc_r   <= '0;
      next_r  <= '0;
      base_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      cnt_r   <= cnt_nxt;
      rcrc_r  <= rcrc_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      crc_r   <= crc_nxt;
      next_r  <= next_nxt;
      base_r  <= base_nxt;
    end
  end

  a_two_words_end_frame: assert property (@(posedge clk) disable iff (!rst_n)
    push.wr1 |-> (push.wr0 && res1.kind && res1.last && !res0.kind && !res0.last))
    else $error("second word is not a frame-end report");

  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HDR) |-> (cnt_r <= HDR_LEN_END))
    else $error("header index out of range");

endmodule
`default_nettype wire

[hw/rtl/scbd_rq.sv]
`default_nettype none
module scbd_rq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire scbd_pkg::push_t push,
  input  wire scbd_pkg::res_t  res0,
  input  wire scbd_pkg::res_t  res1,
  input  wire logic           rd,
  output logic                room,
  output logic                out_valid,
  output scbd_pkg::res_t      out_res
);
  import scbd_pkg::*;

  res_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_CW-1:0] cnt_r;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  assign pop       = out_valid && rd;
  assign room      = (cnt_r <= Q_READY_MAX);

  always_ff @(posedge clk) begin
    if (push.wr0) mem_r[wp_r] <= res0;
    if (push.wr1) mem_r[wp_r + Q_AW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + Q_AW'(push.wr0) + Q_AW'(push.wr1);
      rp_r  <= rp_r + Q_AW'(pop);
      cnt_r <= cnt_r + Q_CW'(push.wr0) + Q_CW'(push.wr1) - Q_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH))
    else $error("result queue overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.wr0) |=> (cnt_r == $past(cnt_r) - Q_CW'(1)))
    else $error("queue count lost a pop");

endmodule
`default_nettype wire
